// ===== rtl/core/cte_pkg.sv =====
`default_nettype none

package cte_pkg;

    localparam int BUF_BYTES = 9;
    localparam int BUF_W     = 8 * BUF_BYTES;
    localparam int LEN_W     = 4;

    typedef logic [3:0]       t_kind;
    typedef logic [2:0]       t_err;
    typedef logic [LEN_W-1:0] t_len;
    typedef logic [BUF_W-1:0] t_buf;

    localparam t_kind K_UINT    = 4'd0;
    localparam t_kind K_NINT    = 4'd1;
    localparam t_kind K_BYTES   = 4'd2;
    localparam t_kind K_TEXT    = 4'd3;
    localparam t_kind K_ARRAY   = 4'd4;
    localparam t_kind K_MAP     = 4'd5;
    localparam t_kind K_TAG     = 4'd6;
    localparam t_kind K_STOP    = 4'd7;
    localparam t_kind K_FP32    = 4'd8;
    localparam t_kind K_FP64    = 4'd9;
    localparam t_kind K_BOOL    = 4'd10;
    localparam t_kind K_NULL    = 4'd11;
    localparam t_kind K_UNDEF   = 4'd12;
    localparam t_kind K_PAYLOAD = 4'd13;

    localparam t_err ERR_OK       = 3'd0;
    localparam t_err ERR_FULL     = 3'd1;
    localparam t_err ERR_INDEF    = 3'd2;
    localparam t_err ERR_ODD_MAP  = 3'd3;
    localparam t_err ERR_BAD_KIND = 3'd4;

    localparam logic       CFG_CAPACITY = 1'b0;
    localparam logic       CFG_STRICT   = 1'b1;

    localparam logic [4:0] AI_MAX_IMM = 5'd23;
    localparam logic [4:0] AI_ARG8    = 5'd24;
    localparam logic [4:0] AI_ARG16   = 5'd25;
    localparam logic [4:0] AI_ARG32   = 5'd26;
    localparam logic [4:0] AI_ARG64   = 5'd27;
    localparam logic [4:0] AI_INDEF   = 5'h1f;

    localparam logic [7:0] IB_STOP  = 8'hFF;
    localparam logic [7:0] IB_FP32  = 8'hFA;
    localparam logic [7:0] IB_FP64  = 8'hFB;
    localparam logic [7:0] IB_FALSE = 8'hF4;
    localparam logic [7:0] IB_TRUE  = 8'hF5;
    localparam logic [7:0] IB_NULL  = 8'hF6;
    localparam logic [7:0] IB_UNDEF = 8'hF7;

    typedef struct packed {
        t_buf bytes;
        t_len len;
        t_err err;
    } t_enc;

    function automatic t_enc make_head(input logic [2:0] mt, input logic [63:0] arg);
        t_enc h;
        h.err = ERR_OK;
        if (arg <= 64'(AI_MAX_IMM)) begin
            h.bytes = {mt, arg[4:0], 64'd0};
            h.len   = t_len'(1);
        end else if (arg <= 64'h0000_0000_0000_00FF) begin
            h.bytes = {mt, AI_ARG8, arg[7:0], 56'd0};
            h.len   = t_len'(2);
        end else if (arg <= 64'h0000_0000_0000_FFFF) begin
            h.bytes = {mt, AI_ARG16, arg[15:0], 48'd0};
            h.len   = t_len'(3);
        end else if (arg <= 64'h0000_0000_FFFF_FFFF) begin
            h.bytes = {mt, AI_ARG32, arg[31:0], 32'd0};
            h.len   = t_len'(5);
        end else begin
            h.bytes = {mt, AI_ARG64, arg};
            h.len   = t_len'(9);
        end
        return h;
    endfunction

    function automatic t_enc encode(
        input t_kind       kind,
        input logic [63:0] value,
        input logic        indef,
        input logic        strict,
        input logic [31:0] room_left
    );
        t_enc e;
        e.bytes = '0;
        e.len   = t_len'(1);
        e.err   = ERR_OK;
        case (kind)
            K_UINT, K_TAG: e = make_head(kind[2:0], value);
            K_NINT:        e = make_head(kind[2:0], ~value);
            K_BYTES, K_TEXT, K_ARRAY, K_MAP: begin
                if (indef) begin
                    if (strict) begin
                        e.err = ERR_INDEF;
                    end else begin
                        e.bytes = {kind[2:0], AI_INDEF, 64'd0};
                        e.len   = t_len'(1);
                    end
                end else if (kind == K_MAP) begin
                    if (value[0]) begin
                        e.err = ERR_ODD_MAP;
                    end else begin
                        e = make_head(kind[2:0], {1'b0, value[63:1]});
                    end
                end else begin
                    e = make_head(kind[2:0], value);
                end
            end
            K_STOP:    e.bytes = {IB_STOP, 64'd0};
            K_FP32: begin
                e.bytes = {IB_FP32, value[31:0], 32'd0};
                e.len   = t_len'(5);
            end
            K_FP64: begin
                e.bytes = {IB_FP64, value};
                e.len   = t_len'(9);
            end
            K_BOOL:    e.bytes = {((value != 64'd0) ? IB_TRUE : IB_FALSE), 64'd0};
            K_NULL:    e.bytes = {IB_NULL, 64'd0};
            K_UNDEF:   e.bytes = {IB_UNDEF, 64'd0};
            K_PAYLOAD: e.bytes = {value[7:0], 64'd0};
            default:   e.err = ERR_BAD_KIND;
        endcase
        if (room_left == 32'd0) begin
            e.err = ERR_FULL;
        end else if (e.err == ERR_OK && 32'(e.len) > room_left) begin
            e.err = ERR_FULL;
        end
        if (e.err != ERR_OK) begin
            e.bytes = '0;
            e.len   = t_len'(1);
        end
        return e;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cbor_token_encoder.sv =====
// CBOR token encoder.
// Input channel: i_in_valid / o_in_stall carry one token (i_kind, i_value,
// i_indefinite); a request is taken at an edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall carry one encoded byte per request,
// with o_last_byte on the final byte of a token, o_error_code and the running
// o_bytes_written count. A refused token gives one request with error set.
// Config channel: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// index 0 loads the buffer capacity into bytes left, index 1 sets strict mode.
// The first byte of a token shows after it moves from the input register into
// the output shifter, which sends one byte per cycle while i_out_stall is low;
// a token has 1 to 9 bytes, and one-byte tokens then flow every cycle.
// A token waits in the input register while the shifter drains the previous
// one, so the next request is taken while the current bytes go out.
// Reset (i_rst_n low, synchronous) empties both stages, clears bytes left,
// the internal written count and strict mode (not o_bytes_written). While
// i_out_stall is high the shown byte holds and the input stalls once the input register is full.
`default_nettype none

module cbor_token_encoder
    import cte_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [3:0]  i_kind,
    input  wire logic [63:0] i_value,
    input  wire logic        i_indefinite,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_last_byte,
    output logic [2:0]       o_error_code,
    output logic [31:0]      o_bytes_written,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    logic        r_iv;
    t_kind       r_kind;
    logic [63:0] r_value;
    logic        r_indef;

    logic        r_ov;
    t_buf        r_buf;
    t_len        r_rem;
    t_err        r_err;
    logic [31:0] r_wc;

    logic        r_strict;
    logic [31:0] r_room_left;
    logic [31:0] r_written_count;
    logic [31:0] n_room_left;
    logic [31:0] n_written_count;

    t_enc        enc;
    logic        pop;
    logic        load;
    logic        in_take;
    logic        cfg_wr;

    assign enc     = encode(r_kind, r_value, r_indef, r_strict, r_room_left);
    assign pop     = r_ov && !i_out_stall;
    assign load    = r_iv && (!r_ov || (pop && o_last_byte));
    assign in_take = i_in_valid && !o_in_stall;
    assign cfg_wr  = i_cfg_valid && o_cfg_ready;

    assign o_in_stall      = r_iv && !load;
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_ov;
    assign o_out_byte      = r_buf[BUF_W-1 -: 8];
    assign o_last_byte     = (r_rem == t_len'(1));
    assign o_error_code    = r_err;
    assign o_bytes_written = r_wc;

    always_comb begin
        n_room_left     = r_room_left;
        n_written_count = r_written_count;
        if (load && enc.err == ERR_OK) begin
            n_room_left     = r_room_left - 32'(enc.len);
            n_written_count = r_written_count + 32'(enc.len);
        end
        if (cfg_wr && i_cfg_index == CFG_CAPACITY) begin
            n_room_left = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv            <= 1'b0;
            r_ov            <= 1'b0;
            r_rem           <= '0;
            r_strict        <= 1'b0;
            r_room_left     <= '0;
            r_written_count <= '0;
        end else begin
            r_room_left     <= n_room_left;
            r_written_count <= n_written_count;
            if (cfg_wr && i_cfg_index == CFG_STRICT) begin
                r_strict <= i_cfg_data[0];
            end
            if (in_take) begin
                r_iv <= 1'b1;
            end else if (load) begin
                r_iv <= 1'b0;
            end
            if (load) begin
                r_ov  <= 1'b1;
                r_rem <= enc.len;
            end else if (pop) begin
                r_ov  <= !o_last_byte;
                r_rem <= r_rem - t_len'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind  <= i_kind;
            r_value <= i_value;
            r_indef <= i_indefinite;
        end
        if (load) begin
            r_buf <= enc.bytes;
            r_err <= enc.err;
            r_wc  <= (enc.err == ERR_OK) ? r_written_count + 32'd1 : r_written_count;
        end else if (pop) begin
            r_buf <= {r_buf[BUF_W-9:0], 8'd0};
            r_wc  <= r_wc + 32'd1;
        end
    end

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_err != ERR_OK) |-> o_last_byte)
        else $error("error request not marked last");

    a_last_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && o_last_byte) |-> (o_bytes_written == r_written_count))
        else $error("written count out of step on last byte");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_rem != t_len'(0) && r_rem <= t_len'(BUF_BYTES)))
        else $error("byte count out of range");

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_iv && !load) |=> (r_iv && $stable(r_kind) && $stable(r_value)))
        else $error("waiting token lost");

endmodule

`default_nettype wire
